[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl files
// each macro expects clk and rst_n to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ZTPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ZTPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ztpd_pkg.sv]
// ----------------------------------------------------------------------------
// ztpd_pkg
// Shared widths, codes and lane/merge result types of the touch detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ztpd_pkg;

  localparam int ZONE_MAX = 6;
  localparam int RD_W     = 16;
  localparam int DIFF_W   = RD_W + 1;
  localparam int CNT_W    = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  // mode codes
  localparam logic [1:0] MODE_POLL = 2'd0;
  localparam logic [1:0] MODE_DOWN = 2'd1;
  localparam logic [1:0] MODE_UP   = 2'd2;

  // status codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BASE   = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_DOWN   = 3'd3;
  localparam logic [2:0] ST_RECAP  = 3'd4;
  localparam logic [2:0] ST_UP     = 3'd5;
  localparam logic [2:0] ST_NOBASE = 3'd6;

  // wait phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DOWN = 2'd1;
  localparam logic [1:0] PH_UP   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DOWN_THR = 2'd0;
  localparam logic [1:0] CFG_UP_MARG  = 2'd1;
  localparam logic [1:0] CFG_POLLS    = 2'd2;

  // per-zone finding
  typedef struct packed {
    logic signed [DIFF_W-1:0] drop;
    logic signed [DIFF_W-1:0] rise;
    logic                     drop_hit;
    logic                     rise_hit;
    logic                     in_margin;
  } lane_t;

  // combined finding over all zones
  typedef struct packed {
    logic signed [DIFF_W-1:0] peak_drop;
    logic signed [DIFF_W-1:0] peak_rise;
    logic                     drop_hit;
    logic                     rise_hit;
    logic                     in_margin;
  } merge_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 4'd1;
  endfunction

endpackage

[hw/rtl/ztpd_if.sv]
// ----------------------------------------------------------------------------
// ztpd_in_if / ztpd_out_if
// Valid/ready channels carrying zone polls in and detector results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ztpd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] zone_0;
  logic [15:0] zone_1;
  logic [15:0] zone_2;
  logic [15:0] zone_3;
  logic [15:0] zone_4;
  logic [15:0] zone_5;

  modport source (output valid, mode, zone_0, zone_1, zone_2, zone_3, zone_4, zone_5,
                  input ready);
  modport sink   (input valid, mode, zone_0, zone_1, zone_2, zone_3, zone_4, zone_5,
                  output ready);
endinterface

interface ztpd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [16:0] largest_drop;
  logic signed [16:0] largest_rise;
  logic [3:0]         drop_run;
  logic [3:0]         rise_run;

  modport source (output valid, status, largest_drop, largest_rise, drop_run, rise_run,
                  input ready);
  modport sink   (input valid, status, largest_drop, largest_rise, drop_run, rise_run,
                  output ready);
endinterface

[hw/rtl/ztpd_lane.sv]
// ----------------------------------------------------------------------------
// ztpd_lane
// One zone: difference against baseline and threshold/margin checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ztpd_lane (
  input  logic [15:0]     base,
  input  logic [15:0]     reading,
  input  logic [15:0]     thr,
  input  logic [15:0]     margin,
  output ztpd_pkg::lane_t res
);
  import ztpd_pkg::*;

  logic signed [DIFF_W-1:0] drop;
  logic signed [DIFF_W-1:0] rise;
  logic signed [DIFF_W-1:0] thr_s;
  logic signed [DIFF_W-1:0] marg_s;

  // signed differences in both directions
  assign drop   = $signed({1'b0, base}) - $signed({1'b0, reading});
  assign rise   = $signed({1'b0, reading}) - $signed({1'b0, base});
  assign thr_s  = $signed({1'b0, thr});
  assign marg_s = $signed({1'b0, margin});

  // per-zone checks, any/all combined in the merge stage
  always_comb begin
    res.drop      = drop;
    res.rise      = rise;
    res.drop_hit  = (drop >= thr_s);
    res.rise_hit  = (rise >= thr_s);
    res.in_margin = (drop <= marg_s) && (rise <= marg_s);
  end

endmodule

[hw/rtl/ztpd_merge.sv]
// ----------------------------------------------------------------------------
// ztpd_merge
// Combines lane findings: largest drop and rise, any-hit and all-within.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ztpd_merge #(
  parameter int LANES = 6
) (
  input  ztpd_pkg::lane_t [LANES-1:0] lanes,
  output ztpd_pkg::merge_t            res
);
  import ztpd_pkg::*;

  // running max and flags across lanes
  always_comb begin
    res.peak_drop = lanes[0].drop;
    res.peak_rise = lanes[0].rise;
    res.drop_hit  = lanes[0].drop_hit;
    res.rise_hit  = lanes[0].rise_hit;
    res.in_margin = lanes[0].in_margin;
    for (int i = 1; i < LANES; i++) begin
      if (lanes[i].drop > res.peak_drop) res.peak_drop = lanes[i].drop;
      if (lanes[i].rise > res.peak_rise) res.peak_rise = lanes[i].rise;
      res.drop_hit  = res.drop_hit | lanes[i].drop_hit;
      res.rise_hit  = res.rise_hit | lanes[i].rise_hit;
      res.in_margin = res.in_margin & lanes[i].in_margin;
    end
  end

endmodule

[hw/rtl/zone_touch_presence_detector_core.sv]
// ----------------------------------------------------------------------------
// zone_touch_presence_detector_core
// Finger-down / finger-up detection over capacitive zone polls.
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------------
//   in_ch   | in  | mode, zone_0 .. zone_5
//   out_ch  | out | status, largest_drop, largest_rise, drop_run, rise_run
//   cfg_*   | in  | down_threshold, up_margin, polls_needed by index
//
// One item per cycle while out_ch is not stalled: lanes, merge and the counter
// update settle combinationally and load the output register, so a result appears the cycle after transfer.
// in_ch.ready is high while the output register is empty or being drained.
// Synchronous active-low reset clears phase, counters and baseline valid and
// loads the register defaults; the baseline registers are written by the
// first poll of a down wait and by the first poll after a recapture.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module zone_touch_presence_detector_core #(
  parameter int ZONE_COUNT = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  ztpd_in_if.sink     in_ch,
  ztpd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_data
);
  import ztpd_pkg::*;

  // configuration
  logic [15:0]      down_thr_r;
  logic [15:0]      up_marg_r;
  logic [CNT_W-1:0] polls_r;

  // detector state
  logic [1:0]       phase_r, phase_nxt;
  logic             bv_r, bv_nxt;
  logic [15:0]      baseline_r [ZONE_COUNT];
  logic [CNT_W-1:0] qual_r, qual_nxt;
  logic [CNT_W-1:0] rise_r, rise_nxt;

  // output register
  logic                     ovalid_r;
  logic [2:0]               ostatus_r, status_nxt;
  logic signed [DIFF_W-1:0] odrop_r, drop_nxt;
  logic signed [DIFF_W-1:0] orise_r, rise_v_nxt;
  logic [CNT_W-1:0]         odrun_r, drun_nxt;
  logic [CNT_W-1:0]         orrun_r, rrun_nxt;

  logic                          in_fire;
  logic                          capture;
  logic [ZONE_MAX-1:0][15:0]     rd;
  lane_t [ZONE_COUNT-1:0]        lane_res;
  merge_t                        mres;
  logic [CNT_W-1:0]              q_eval, r_eval;

  assign rd = {in_ch.zone_5, in_ch.zone_4, in_ch.zone_3,
               in_ch.zone_2, in_ch.zone_1, in_ch.zone_0};

  assign in_ch.ready = !ovalid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // one lane per zone
  for (genvar g = 0; g < ZONE_COUNT; g++) begin : g_lane
    ztpd_lane u_lane (
      .base    (baseline_r[g]),
      .reading (rd[g]),
      .thr     (down_thr_r),
      .margin  (up_marg_r),
      .res     (lane_res[g])
    );
  end

  ztpd_merge #(.LANES(ZONE_COUNT)) u_merge (
    .lanes (lane_res),
    .res   (mres)
  );

  // next state and result for the offered item
  always_comb begin
    phase_nxt  = phase_r;
    bv_nxt     = bv_r;
    qual_nxt   = qual_r;
    rise_nxt   = rise_r;
    status_nxt = ST_IDLE;
    drop_nxt   = '0;
    rise_v_nxt = '0;
    capture    = 1'b0;
    q_eval     = qual_r;
    r_eval     = rise_r;
    priority if (in_ch.mode == MODE_DOWN) begin
      bv_nxt     = 1'b0;
      q_eval     = '0;
      r_eval     = '0;
      phase_nxt  = PH_DOWN;
      status_nxt = ST_WAIT;
    end else if (in_ch.mode == MODE_UP) begin
      if (!bv_r) begin
        phase_nxt  = PH_IDLE;
        status_nxt = ST_NOBASE;
      end else begin
        q_eval     = '0;
        phase_nxt  = PH_UP;
        status_nxt = ST_WAIT;
      end
    end else if (in_ch.mode == MODE_POLL &&
                 (phase_r == PH_DOWN || phase_r == PH_UP)) begin
      if (!bv_r) begin
        capture    = 1'b1;
        bv_nxt     = 1'b1;
        status_nxt = ST_BASE;
      end else begin
        drop_nxt   = mres.peak_drop;
        rise_v_nxt = mres.peak_rise;
        if (phase_r == PH_DOWN) begin
          r_eval = mres.rise_hit ? sat_inc(rise_r) : '0;
          q_eval = mres.drop_hit ? sat_inc(qual_r) : '0;
          priority if (r_eval >= polls_r) begin
            status_nxt = ST_RECAP;
          end else if (q_eval >= polls_r) begin
            status_nxt = ST_DOWN;
            phase_nxt  = PH_IDLE;
          end else begin
            status_nxt = ST_WAIT;
          end
        end else begin
          q_eval = mres.in_margin ? sat_inc(qual_r) : '0;
          if (q_eval >= polls_r) begin
            status_nxt = ST_UP;
            phase_nxt  = PH_IDLE;
          end else begin
            status_nxt = ST_WAIT;
          end
        end
      end
    end else begin
      status_nxt = ST_IDLE;
    end
    drun_nxt = q_eval;
    rrun_nxt = r_eval;
    qual_nxt = q_eval;
    rise_nxt = r_eval;
    // recapture drops the baseline and restarts both runs
    if (status_nxt == ST_RECAP) begin
      bv_nxt   = 1'b0;
      qual_nxt = '0;
      rise_nxt = '0;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_thr_r <= 16'd20;
      up_marg_r  <= 16'd10;
      polls_r    <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DOWN_THR: down_thr_r <= cfg_data;
        CFG_UP_MARG:  up_marg_r  <= cfg_data;
        CFG_POLLS:    polls_r    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      bv_r     <= 1'b0;
      qual_r   <= '0;
      rise_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        bv_r    <= bv_nxt;
        qual_r  <= qual_nxt;
        rise_r  <= rise_nxt;
      end
      if (in_fire) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // baseline capture
  always_ff @(posedge clk) begin
    if (in_fire && capture) begin
      for (int i = 0; i < ZONE_COUNT; i++) begin
        baseline_r[i] <= rd[i];
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ostatus_r <= status_nxt;
      odrop_r   <= drop_nxt;
      orise_r   <= rise_v_nxt;
      odrun_r   <= drun_nxt;
      orrun_r   <= rrun_nxt;
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.status       = ostatus_r;
  assign out_ch.largest_drop = odrop_r;
  assign out_ch.largest_rise = orise_r;
  assign out_ch.drop_run     = odrun_r;
  assign out_ch.rise_run     = orrun_r;

  // checks
  `ZTPD_ASSERT_SAME(a_up_has_base, phase_r == PH_UP, bv_r, "up wait without baseline")
  `ZTPD_ASSERT_NEXT(a_recap_clears, in_fire && status_nxt == ST_RECAP,
                    !bv_r && qual_r == '0 && rise_r == '0, "recapture left state behind")
  `ZTPD_ASSERT_NEXT(a_touch_idles, in_fire && (status_nxt == ST_DOWN || status_nxt == ST_UP),
                    phase_r == PH_IDLE, "wait not ended after touch change")
  `ZTPD_ASSERT_NEXT(a_result_loaded, in_fire, ovalid_r, "transfer produced no result")

endmodule

[tb/tb_zone_touch_presence_detector_core.sv]
// ----------------------------------------------------------------------------
// tb_zone_touch_presence_detector_core
// Self-checking bench for the zone touch detector: a directed table walks the
// reset state, the extreme readings and every command, then randomized
// down/up wait sessions run under several register settings and flow-control
// patterns, checked against typed table rows or an in-bench detector model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_zone_touch_presence_detector_core;
  import ztpd_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int ZONES = ZONE_MAX;
  localparam int WD_LIMIT = 2000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 135;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic [1:0]       mode;
    logic [0:5][15:0] zone;
  } poll_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [16:0] drop;
    logic signed [16:0] rise;
    logic [3:0]         drop_run;
    logic [3:0]         rise_run;
  } report_t;

  typedef struct packed {
    poll_t   poll;
    logic    typed;
    report_t want;
  } feed_item_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    feed_item_t  item;
  } dir_row_t;

  typedef enum int {SH_QUIET, SH_EDGE, SH_TOUCH, SH_RISE, SH_WILD} shape_e;

  // zone patterns for the directed table
  localparam logic [0:5][15:0] Z_ZERO  = '{default: 16'h0000};
  localparam logic [0:5][15:0] Z_MAX   = '{default: 16'hFFFF};
  localparam logic [0:5][15:0] Z_MID   = '{default: 16'd1000};
  localparam logic [0:5][15:0] Z_MIX   = '{16'd0, 16'd65535, 16'd1000, 16'd1000, 16'd1000,
                                           16'd1000};
  localparam logic [0:5][15:0] Z_SWAP  = '{16'd65535, 16'd0, 16'd1000, 16'd1000, 16'd1000,
                                           16'd1000};
  localparam logic [0:5][15:0] Z_DIP   = '{16'd1000, 16'd1000, 16'd970, 16'd1000, 16'd1000,
                                           16'd1000};
  localparam logic [0:5][15:0] Z_DIP2  = '{16'd1000, 16'd1000, 16'd975, 16'd1000, 16'd1000,
                                           16'd1000};
  localparam logic [0:5][15:0] Z_NEAR  = '{16'd1010, 16'd990, 16'd1000, 16'd1005, 16'd995,
                                           16'd1000};
  localparam logic [0:5][15:0] Z_OUT   = '{16'd1000, 16'd1000, 16'd1000, 16'd1011, 16'd1000,
                                           16'd1000};

  // results that can be read off directly
  localparam report_t R_NONE   = '0;
  localparam report_t R_IDLE   = '{ST_IDLE, 17'sd0, 17'sd0, 4'd0, 4'd0};
  localparam report_t R_NOBASE = '{ST_NOBASE, 17'sd0, 17'sd0, 4'd0, 4'd0};
  localparam report_t R_WAIT0  = '{ST_WAIT, 17'sd0, 17'sd0, 4'd0, 4'd0};
  localparam report_t R_BASE   = '{ST_BASE, 17'sd0, 17'sd0, 4'd0, 4'd0};
  localparam report_t R_SWAP1  = '{ST_WAIT, 17'sd65535, 17'sd65535, 4'd1, 4'd1};
  localparam report_t R_SWAP2  = '{ST_RECAP, 17'sd65535, 17'sd65535, 4'd2, 4'd2};
  localparam report_t R_LOW    = '{ST_WAIT, -17'sd65535, 17'sd65535, 4'd0, 4'd1};
  localparam feed_item_t NO_ITEM = '0;

  // directed stimulus, default registers until the first register row
  localparam int DIR_ROWS = 31;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // poll and unused mode while idle, up wait with no baseline
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_MAX}, 1'b1, R_IDLE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_NONE, Z_MAX}, 1'b1, R_IDLE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_UP, Z_ZERO}, 1'b1, R_NOBASE}},
    // down wait, extreme baseline, rise and drop together -> recapture wins
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_DOWN, Z_ZERO}, 1'b1, R_WAIT0}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_MIX}, 1'b1, R_BASE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_SWAP}, 1'b1, R_SWAP1}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_SWAP}, 1'b1, R_SWAP2}},
    // recapture keeps the down wait going: next poll is the new baseline
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_ZERO}, 1'b1, R_BASE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_MAX}, 1'b1, R_LOW}},
    // fresh down wait, touch after two drops
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_DOWN, Z_MAX}, 1'b1, R_WAIT0}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_MID}, 1'b1, R_BASE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_MID}, 1'b0, R_NONE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_DIP}, 1'b0, R_NONE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_DIP2}, 1'b0, R_NONE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_MID}, 1'b0, R_NONE}},
    // up wait, run broken once by a zone just outside the margin
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_UP, Z_MID}, 1'b0, R_NONE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_NEAR}, 1'b0, R_NONE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_OUT}, 1'b0, R_NONE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_NEAR}, 1'b0, R_NONE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_NEAR}, 1'b0, R_NONE}},
    // zero poll count: the first evaluated poll changes state
    '{ROW_CFG, CFG_POLLS, 16'd0, NO_ITEM},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_DOWN, Z_MID}, 1'b0, R_NONE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_MID}, 1'b0, R_NONE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_DIP}, 1'b0, R_NONE}},
    // extreme register values
    '{ROW_CFG, CFG_DOWN_THR, 16'hFFFF, NO_ITEM},
    '{ROW_CFG, CFG_UP_MARG, 16'h0000, NO_ITEM},
    '{ROW_CFG, CFG_POLLS, 16'd15, NO_ITEM},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_MID}, 1'b0, R_NONE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_MID}, 1'b0, R_NONE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_UP, Z_MID}, 1'b0, R_NONE}},
    '{ROW_ITEM, CFG_DOWN_THR, 16'd0, '{'{MODE_POLL, Z_MID}, 1'b0, R_NONE}}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;

  ztpd_in_if  in_ch ();
  ztpd_out_if out_ch ();

  zone_touch_presence_detector_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  // bench state
  feed_item_t poll_feed [$];
  report_t    pending_reports [$];
  feed_item_t offered;
  bit         in_took = 1'b0;
  int         errors = 0;
  int         idle_cycles = 0;
  int         src_idle_pct = 0;
  int         snk_stall_pct = 0;
  int         hold_left = 0;
  int         queued = 0;

  // detector model: registers and state
  int          thr_reg = 20;
  int          marg_reg = 10;
  int          need_reg = 2;
  logic [1:0]  wait_ph = PH_IDLE;
  bit          have_base = 1'b0;
  logic [15:0] base_rd [ZONES];
  logic [3:0]  drop_cnt = 4'd0;
  logic [3:0]  rise_cnt = 4'd0;

  // stimulus generator's view of the current baseline
  logic [15:0] gen_base [ZONES];

  function automatic bit chance(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic logic [3:0] bump(input logic [3:0] c);
    return (c == 4'd15) ? c : c + 4'd1;
  endfunction

  function automatic logic [15:0] clamp16(input int v);
    return (v < 0) ? 16'h0000 : (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // one step of the detector: updates the model state, returns the report
  function automatic report_t next_detection(input poll_t p);
    report_t r;
    int      d;
    int      drop_max;
    int      rise_max;
    bit      quiet;
    r = R_IDLE;
    drop_max = 0;
    rise_max = 0;
    if (p.mode == MODE_DOWN) begin
      have_base = 1'b0;
      drop_cnt = 4'd0;
      rise_cnt = 4'd0;
      wait_ph = PH_DOWN;
      r.status = ST_WAIT;
    end else if (p.mode == MODE_UP) begin
      if (!have_base) begin
        wait_ph = PH_IDLE;
        r.status = ST_NOBASE;
      end else begin
        drop_cnt = 4'd0;
        wait_ph = PH_UP;
        r.status = ST_WAIT;
      end
    end else if (p.mode == MODE_POLL && wait_ph != PH_IDLE) begin
      if (!have_base) begin
        // first poll of the wait becomes the baseline
        for (int i = 0; i < ZONES; i++) base_rd[i] = p.zone[i];
        have_base = 1'b1;
        r.status = ST_BASE;
      end else begin
        quiet = 1'b1;
        for (int i = 0; i < ZONES; i++) begin
          d = int'(base_rd[i]) - int'(p.zone[i]);
          if (i == 0 || d > drop_max) drop_max = d;
          if (i == 0 || -d > rise_max) rise_max = -d;
          if (d > marg_reg || -d > marg_reg) quiet = 1'b0;
        end
        if (wait_ph == PH_DOWN) begin
          rise_cnt = (rise_max >= thr_reg) ? bump(rise_cnt) : 4'd0;
          drop_cnt = (drop_max >= thr_reg) ? bump(drop_cnt) : 4'd0;
          // recapture has priority over touch
          if (rise_cnt >= need_reg) begin
            r.status = ST_RECAP;
          end else if (drop_cnt >= need_reg) begin
            r.status = ST_DOWN;
            wait_ph = PH_IDLE;
          end else begin
            r.status = ST_WAIT;
          end
        end else begin
          drop_cnt = quiet ? bump(drop_cnt) : 4'd0;
          if (drop_cnt >= need_reg) begin
            r.status = ST_UP;
            wait_ph = PH_IDLE;
          end else begin
            r.status = ST_WAIT;
          end
        end
      end
    end
    r.drop = drop_max[16:0];
    r.rise = rise_max[16:0];
    r.drop_run = drop_cnt;
    r.rise_run = rise_cnt;
    if (r.status == ST_RECAP) begin
      have_base = 1'b0;
      drop_cnt = 4'd0;
      rise_cnt = 4'd0;
    end
    return r;
  endfunction

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // monitor: checks results, predicts accepted polls, feeds the watchdog
  always @(posedge clk) begin : monitor
    report_t want;
    report_t got;
    bit      out_took;
    in_took = rst_n && in_ch.valid && in_ch.ready;
    out_took = rst_n && out_ch.valid && out_ch.ready;
    if (out_took) begin
      got.status = out_ch.status;
      got.drop = out_ch.largest_drop;
      got.rise = out_ch.largest_rise;
      got.drop_run = out_ch.drop_run;
      got.rise_run = out_ch.rise_run;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d", $time, got.status);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        cmp_field("status", int'(want.status), int'(got.status));
        cmp_field("largest_drop", int'(want.drop), int'(got.drop));
        cmp_field("largest_rise", int'(want.rise), int'(got.rise));
        cmp_field("drop_run", int'(want.drop_run), int'(got.drop_run));
        cmp_field("rise_run", int'(want.rise_run), int'(got.rise_run));
      end
    end
    if (in_took) begin
      want = next_detection(offered.poll);
      if (offered.typed) want = offered.want;
      pending_reports.push_back(want);
    end
    if (in_took || out_took || cfg_we) idle_cycles = 0;
    else idle_cycles++;
  end

  // poll sender: a new item goes up only once the previous one transferred
  initial begin : feed_driver
    feed_item_t nxt;
    logic       drive;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_POLL;
    in_ch.zone_0 = 16'h0000;
    in_ch.zone_1 = 16'h0000;
    in_ch.zone_2 = 16'h0000;
    in_ch.zone_3 = 16'h0000;
    in_ch.zone_4 = 16'h0000;
    in_ch.zone_5 = 16'h0000;
    forever begin
      @(negedge clk);
      if (!in_ch.valid || in_took) begin
        drive = rst_n && poll_feed.size() != 0 && !chance(src_idle_pct);
        if (drive) begin
          nxt = poll_feed.pop_front();
          offered = nxt;
          in_ch.mode = nxt.poll.mode;
          in_ch.zone_0 = nxt.poll.zone[0];
          in_ch.zone_1 = nxt.poll.zone[1];
          in_ch.zone_2 = nxt.poll.zone[2];
          in_ch.zone_3 = nxt.poll.zone[3];
          in_ch.zone_4 = nxt.poll.zone[4];
          in_ch.zone_5 = nxt.poll.zone[5];
        end
        in_ch.valid = drive;
      end
    end
  end

  // result receiver, with an occasional long hold-off
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = !chance(snk_stall_pct);
      end
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WD_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // called at a falling edge; waits until every transfer has come back
  task automatic wait_drained();
    while (poll_feed.size() != 0 || in_ch.valid || pending_reports.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_DOWN_THR: thr_reg = int'(val);
      CFG_UP_MARG:  marg_reg = int'(val);
      CFG_POLLS:    need_reg = int'(val[3:0]);
      default: ;
    endcase
  endtask

  task automatic queue_item(input feed_item_t f);
    poll_feed.push_back(f);
    queued++;
  endtask

  // command or stray item; zone fields carry random bits either way
  task automatic queue_cmd(input logic [1:0] mode);
    feed_item_t f;
    f = NO_ITEM;
    f.poll.mode = mode;
    for (int i = 0; i < ZONES; i++) f.poll.zone[i] = 16'($urandom_range(65535, 0));
    queue_item(f);
  endtask

  // poll around the generator's baseline, shaped to push one kind of run
  task automatic queue_shaped_poll(input shape_e bias);
    feed_item_t f;
    shape_e     shape;
    int         lim;
    int         pick;
    int         kick;
    f = NO_ITEM;
    f.poll.mode = MODE_POLL;
    shape = chance(85) ? bias : shape_e'($urandom_range(4, 0));
    lim = (marg_reg > 4000) ? 4000 : marg_reg;
    pick = $urandom_range(ZONES - 1, 0);
    kick = chance(10) ? thr_reg - 1 : thr_reg + int'($urandom_range(40, 0));
    for (int i = 0; i < ZONES; i++) begin
      if (shape == SH_WILD) f.poll.zone[i] = 16'($urandom_range(65535, 0));
      else f.poll.zone[i] = clamp16(int'(gen_base[i]) + int'($urandom_range(2 * lim, 0)) - lim);
    end
    case (shape)
      SH_EDGE:  f.poll.zone[pick] = clamp16(int'(gen_base[pick]) +
                                            (chance(50) ? lim + 1 : -lim - 1));
      SH_TOUCH: f.poll.zone[pick] = clamp16(int'(gen_base[pick]) - kick);
      SH_RISE:  f.poll.zone[pick] = clamp16(int'(gen_base[pick]) + kick);
      default: ;
    endcase
    queue_item(f);
  endtask

  // lone command at times; else down wait, shaped polls, mostly an up wait
  task automatic queue_session();
    feed_item_t f;
    shape_e     bias;
    int         roll;
    if (chance(8)) begin
      queue_cmd(2'($urandom_range(3, 0)));
      return;
    end
    queue_cmd(MODE_DOWN);
    f = NO_ITEM;
    f.poll.mode = MODE_POLL;
    for (int i = 0; i < ZONES; i++) begin
      roll = $urandom_range(99, 0);
      if (roll < 15) gen_base[i] = chance(50) ? 16'h0000 : 16'hFFFF;
      else if (roll < 30) gen_base[i] = 16'($urandom_range(65535, 0));
      else gen_base[i] = 16'($urandom_range(60000, 5000));
      f.poll.zone[i] = gen_base[i];
    end
    queue_item(f);
    roll = $urandom_range(99, 0);
    bias = (roll < 60) ? SH_TOUCH : (roll < 80) ? SH_RISE : SH_QUIET;
    repeat (need_reg + $urandom_range(3, 0)) queue_shaped_poll(bias);
    if (chance(70)) begin
      queue_cmd(MODE_UP);
      bias = chance(85) ? SH_QUIET : SH_EDGE;
      repeat (need_reg + $urandom_range(3, 0)) queue_shaped_poll(bias);
    end
  endtask

  // main sequence
  initial begin : run
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_DOWN_THR;
    cfg_data = 16'h0000;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    for (int k = 0; k < DIR_ROWS; k++) begin
      if (DIR_TAB[k].kind == ROW_CFG) begin
        wait_drained();
        write_reg(DIR_TAB[k].reg_idx, DIR_TAB[k].reg_val);
      end else begin
        queue_item(DIR_TAB[k].item);
      end
    end

    // random sessions over several register settings and flow patterns
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
        default: begin src_idle_pct = 8; snk_stall_pct = 8; end
      endcase
      write_reg(CFG_DOWN_THR, (ph == 1) ? 16'h0000 : (ph == 2) ? 16'hFFFF :
                              16'($urandom_range(400, 1)));
      write_reg(CFG_UP_MARG, (ph == 3) ? 16'h0000 : (ph == 4) ? 16'hFFFF :
                             16'($urandom_range(200, 0)));
      write_reg(CFG_POLLS, (ph == 5) ? 16'd15 : (ph == 6) ? 16'd1 :
                           16'($urandom_range(4, 1)));
      queued = 0;
      while (queued < PHASE_ITEMS) queue_session();
      // receiver backs off while the sender keeps offering
      if (ph == 2 || ph == 5) hold_left = HOLD_CYCLES;
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
